// ===== rtl/cft_pkg.sv =====
// Shared types and constants for the CSV field and row tokenizer.
// Holds parse modes, result kinds and the per-byte result bundle; no dependencies.
`default_nettype none

package cft_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntW    = 2;

  localparam logic [ByteW-1:0] DelimReset = 8'd44;  // comma
  localparam logic [ByteW-1:0] ChQuote    = 8'h22;
  localparam logic [ByteW-1:0] ChCr       = 8'h0D;
  localparam logic [ByteW-1:0] ChLf       = 8'h0A;
  localparam logic [ByteW-1:0] ChNul      = 8'h00;

  typedef enum logic [2:0] {
    MODE_ROW    = 3'd0,
    MODE_DELIM  = 3'd1,
    MODE_PLAIN  = 3'd2,
    MODE_QUOTED = 3'd3,
    MODE_QSEEN  = 3'd4,
    MODE_CR     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
  } res_t;

  // All results caused by one input byte, in order from entry 0
  typedef struct packed {
    logic [CntW-1:0]     cnt;
    res_t [MaxRes-1:0]   res;
  } bundle_t;

endpackage

`default_nettype wire

// ===== rtl/csv_field_row_tokenizer_core.sv =====
// Top level of the CSV field and row tokenizer.
// Instantiates cft_parser and cft_emitter; depends on cft_pkg.
//
// Feed CSV text one byte per transaction; each byte yields zero to three results
// (content byte, field end, or field end that also ends the row), delivered in
// order with last_of_run marking the final result of that byte. The parser
// decodes a byte in the cycle it is accepted and stores its results in a small
// bundle register; the output register drains that bundle one result per cycle
// while out_stall_i does not hold it. A new byte is taken as the previous byte's
// last result moves into the output register; the single output register is the
// limit. Results pass the bundle register, then the output register. The
// delimiter register resets to comma and is written by cfg_we_i/cfg_data_i; the
// user must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module csv_field_row_tokenizer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      content_byte_o,
  output logic            last_of_run_o
);
  import cft_pkg::*;

  bundle_t bundle;
  logic    accept;

  assign accept = in_valid_i && !in_stall_o;

  // Decode bytes and track parse mode
  cft_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .bundle_o      (bundle)
  );

  // Queue and deliver the results
  cft_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .bundle_i       (bundle),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .content_byte_o (content_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== rtl/cft_parser.sv =====
// Parse-mode register, delimiter register and per-byte decode logic.
// Depends on cft_pkg; produces a result bundle for each accepted byte.
`default_nettype none

module cft_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 end_of_text_i,
  output cft_pkg::bundle_t          bundle_o
);
  import cft_pkg::*;

  typedef struct packed {
    bundle_t b;
    mode_e   mode;
  } step_t;

  logic [ByteW-1:0] delim_q;
  mode_e            mode_q;
  step_t            step;

  // Append one result to the bundle
  function automatic step_t push(step_t s, kind_e k, logic [ByteW-1:0] d);
    step_t r;
    r = s;
    r.b.res[s.b.cnt] = '{kind: k, data: d};
    r.b.cnt = s.b.cnt + 2'd1;
    return r;
  endfunction

  // Handle a byte where a new field begins
  function automatic step_t begin_field(step_t s, logic [ByteW-1:0] c,
                                        logic [ByteW-1:0] dl);
    step_t r;
    r = s;
    priority if (c == ChQuote) begin
      r.mode = MODE_QUOTED;
    end else if (c == dl) begin
      r = push(r, KIND_FIELD, '0);
      r.mode = MODE_DELIM;
    end else if (c == ChCr) begin
      r = push(r, KIND_ROW, '0);
      r.mode = MODE_CR;
    end else if (c == ChLf) begin
      r = push(r, KIND_ROW, '0);
      r.mode = MODE_ROW;
    end else begin
      r = push(r, KIND_BYTE, c);
      r.mode = MODE_PLAIN;
    end
    return r;
  endfunction

  // Handle the byte that follows a finished field
  function automatic step_t after_field(step_t s, logic [ByteW-1:0] c,
                                        logic [ByteW-1:0] dl);
    step_t r;
    r = s;
    priority if (c == dl) begin
      r = push(r, KIND_FIELD, '0);
      r.mode = MODE_DELIM;
    end else if (c == ChCr) begin
      r = push(r, KIND_ROW, '0);
      r.mode = MODE_CR;
    end else if (c == ChLf) begin
      r = push(r, KIND_ROW, '0);
      r.mode = MODE_ROW;
    end else begin
      // stray byte after a closing quote ends the row and opens the next
      r = push(r, KIND_ROW, '0);
      r.mode = MODE_ROW;
      r = begin_field(r, c, dl);
    end
    return r;
  endfunction

  // Decode the incoming byte against the current mode
  always_comb begin
    step_t s;
    s = '{b: '0, mode: mode_q};
    unique case (mode_q)
      MODE_CR: begin
        if (data_byte_i == ChLf) s.mode = MODE_ROW;
        else                     s = begin_field(s, data_byte_i, delim_q);
      end
      MODE_DELIM: begin
        priority if (data_byte_i == ChCr) begin
          s = push(s, KIND_ROW, '0);
          s.mode = MODE_CR;
        end else if (data_byte_i == ChLf) begin
          s = push(s, KIND_ROW, '0);
          s.mode = MODE_ROW;
        end else if (data_byte_i == ChNul) begin
          s = push(s, KIND_ROW, '0);
          s = begin_field(s, data_byte_i, delim_q);
        end else begin
          s = begin_field(s, data_byte_i, delim_q);
        end
      end
      MODE_PLAIN: begin
        if (data_byte_i == delim_q || data_byte_i == ChCr || data_byte_i == ChLf)
          s = after_field(s, data_byte_i, delim_q);
        else
          s = push(s, KIND_BYTE, data_byte_i);
      end
      MODE_QUOTED: begin
        if (data_byte_i == ChQuote) s.mode = MODE_QSEEN;
        else                        s = push(s, KIND_BYTE, data_byte_i);
      end
      MODE_QSEEN: begin
        if (data_byte_i == ChQuote) begin
          s = push(s, KIND_BYTE, data_byte_i);
          s.mode = MODE_QUOTED;
        end else begin
          s = after_field(s, data_byte_i, delim_q);
        end
      end
      default: s = begin_field(s, data_byte_i, delim_q);
    endcase

    // Close an open field at end of text
    if (end_of_text_i) begin
      if (s.mode == MODE_DELIM || s.mode == MODE_PLAIN ||
          s.mode == MODE_QUOTED || s.mode == MODE_QSEEN)
        s = push(s, KIND_ROW, '0);
      s.mode = MODE_ROW;
    end
    step = s;
  end

  assign bundle_o = step.b;

  // Hold the delimiter and advance the mode on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
      mode_q  <= MODE_ROW;
    end else begin
      if (cfg_we_i) delim_q <= cfg_data_i;
      if (accept_i) mode_q  <= step.mode;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cft_emitter.sv =====
// Bundle register and output register: drains each byte's results one per cycle
// while unstalled; depends on cft_pkg for the bundle and result types.
`default_nettype none

module cft_emitter (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire cft_pkg::bundle_t     bundle_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                content_byte_o,
  output logic                      last_of_run_o
);
  import cft_pkg::*;

  logic [CntW-1:0]   rem_q, rem_d;
  res_t [MaxRes-1:0] res_q, res_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q, out_res_d;
  logic              out_last_q, out_last_d;
  logic              out_free, take, accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign take       = (rem_q != '0) && out_free;
  assign in_stall_o = !((rem_q == '0) || (out_free && rem_q == CntW'(1)));
  assign accept     = in_valid_i && !in_stall_o;

  // Load a new bundle or shift out the head entry
  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    if (accept) begin
      rem_d = bundle_i.cnt;
      res_d = bundle_i.res;
    end else if (take) begin
      rem_d    = rem_q - CntW'(1);
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      res_d[2] = '0;
    end
  end

  // Fill the output register whenever it frees up
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_last_d  = out_last_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_res_d   = res_q[0];
      out_last_d  = (rem_q == CntW'(1));
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_res_q.kind;
  assign content_byte_o = out_res_q.data;
  assign last_of_run_o  = out_last_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for csv_field_row_tokenizer_core: drives CSV text bytes, predicts the
// token stream with its own parser copy and checks every result in order.
// Depends on cft_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import cft_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eot;
  } text_byte_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_text = 1'b0;
  logic       out_stall = 1'b1;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] content_byte;
  logic       last_of_run;

  text_byte_t text_q[$];   // bytes waiting to be offered
  tok_t       tok_q[$];    // predicted tokens, oldest first
  tok_t       run_q[$];    // tokens of the byte being predicted

  mode_e      tb_mode = MODE_ROW;
  logic [7:0] tb_delim = DelimReset;

  int  push_count = 0;
  int  acc_count = 0;
  int  err_count = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  logic in_acc = 1'b0;
  logic rx_hold = 1'b0;
  logic calm = 1'b0;

  csv_field_row_tokenizer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .content_byte_o (content_byte),
    .last_of_run_o  (last_of_run)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- parser copy

  task automatic add_token(input kind_e k, input logic [7:0] d);
    tok_t t;
    t.kind = k;
    t.data = d;
    t.last = 1'b0;
    run_q.push_back(t);
  endtask

  // Byte where a new field begins: quote first, then delimiter, then line ends
  task automatic start_field(input logic [7:0] c);
    if (c == ChQuote) begin
      tb_mode = MODE_QUOTED;
    end else if (c == tb_delim) begin
      add_token(KIND_FIELD, 8'd0);
      tb_mode = MODE_DELIM;
    end else if (c == ChCr) begin
      add_token(KIND_ROW, 8'd0);
      tb_mode = MODE_CR;
    end else if (c == ChLf) begin
      add_token(KIND_ROW, 8'd0);
      tb_mode = MODE_ROW;
    end else begin
      add_token(KIND_BYTE, c);
      tb_mode = MODE_PLAIN;
    end
  endtask

  // Byte after a finished field; anything but a separator ends the row and restarts
  task automatic close_field(input logic [7:0] c);
    if (c == tb_delim) begin
      add_token(KIND_FIELD, 8'd0);
      tb_mode = MODE_DELIM;
    end else if (c == ChCr) begin
      add_token(KIND_ROW, 8'd0);
      tb_mode = MODE_CR;
    end else if (c == ChLf) begin
      add_token(KIND_ROW, 8'd0);
      tb_mode = MODE_ROW;
    end else begin
      add_token(KIND_ROW, 8'd0);
      tb_mode = MODE_ROW;
      start_field(c);
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eot);
    run_q.delete();
    case (tb_mode)
      MODE_CR: begin
        if (c == ChLf) tb_mode = MODE_ROW;
        else start_field(c);
      end
      MODE_DELIM: begin
        if (c == ChCr || c == ChLf || c == ChNul) begin
          add_token(KIND_ROW, 8'd0);
          if (c == ChCr) begin
            tb_mode = MODE_CR;
          end else if (c == ChLf) begin
            tb_mode = MODE_ROW;
          end else begin
            tb_mode = MODE_ROW;
            start_field(c);
          end
        end else begin
          start_field(c);
        end
      end
      MODE_PLAIN: begin
        if (c == tb_delim || c == ChCr || c == ChLf) close_field(c);
        else add_token(KIND_BYTE, c);
      end
      MODE_QUOTED: begin
        if (c == ChQuote) tb_mode = MODE_QSEEN;
        else add_token(KIND_BYTE, c);
      end
      MODE_QSEEN: begin
        if (c == ChQuote) begin
          add_token(KIND_BYTE, c);
          tb_mode = MODE_QUOTED;
        end else begin
          close_field(c);
        end
      end
      default: start_field(c);
    endcase
    // Flush: close whatever field is still open
    if (eot) begin
      if (tb_mode == MODE_DELIM || tb_mode == MODE_PLAIN ||
          tb_mode == MODE_QUOTED || tb_mode == MODE_QSEEN)
        add_token(KIND_ROW, 8'd0);
      tb_mode = MODE_ROW;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) tok_q.push_back(run_q[i]);
  endtask

  // ---------------------------------------------------------------- helpers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 50)
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic push_item(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t.b = b;
    t.eot = eot;
    text_q.push_back(t);
    push_count++;
  endtask

  // Content byte that cannot end or open a field
  function automatic logic [7:0] plain_byte(input logic [7:0] dl);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == dl || b == ChCr || b == ChLf || b == ChQuote || b == ChNul);
    return b;
  endfunction

  // One well-formed record with random content and a random line end
  task automatic gen_record(input logic [7:0] dl);
    int nf;
    int len;
    logic [7:0] b;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_item(dl, 1'b0);
      len = $urandom_range(0, 4);
      if ($urandom_range(0, 1)) begin
        push_item(ChQuote, 1'b0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            push_item(ChQuote, 1'b0);
            push_item(ChQuote, 1'b0);
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == ChQuote);
            push_item(b, 1'b0);
          end
        end
        push_item(ChQuote, 1'b0);
      end else begin
        for (int k = 0; k < len; k++) push_item(plain_byte(dl), 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        push_item(ChCr, 1'b0);
        push_item(ChLf, 1'b0);
      end
      1: push_item(ChCr, 1'b0);
      2: push_item(ChLf, 1'b0);
      default: push_item(ChLf, 1'b1);
    endcase
  endtask

  // Mostly records, some raw noise and random end-of-text marks
  task automatic gen_phase(input int count);
    int start;
    start = push_count;
    while (push_count - start < count) begin
      if ($urandom_range(0, 9) < 8) begin
        gen_record(tb_delim);
      end else begin
        repeat ($urandom_range(1, 6))
          push_item(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
    end
  endtask

  // Hold until every byte is taken and every token has come, then let the pipe empty
  task automatic wait_drained();
    while (acc_count != push_count || tok_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] d);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= d;
    tb_delim = d;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- driver

  // Offer the next byte once the current transaction is taken
  always @(negedge clk_i) begin : drive_bytes
    text_byte_t t;
    if (!in_valid || in_acc) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (rst_ni && text_q.size() > 0) begin
        t = text_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= t.b;
        end_of_text <= t.eot;
        tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict tokens for each accepted byte
  always @(posedge clk_i) begin : accept_bytes
    if (rst_ni && in_valid && !in_stall) begin
      tokenize_byte(data_byte, end_of_text);
      acc_count++;
      in_acc <= 1'b1;
    end else begin
      in_acc <= 1'b0;
    end
  end

  // Stall the output at random, or for the long hold
  always @(negedge clk_i) begin : drive_stall
    if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_hold;
      if (!rx_hold) rx_gap = pick_gap();
    end
  end

  // Toggle stretches without idling
  always @(posedge clk_i) begin : toggle_calm
    if ($urandom_range(0, 199) == 0) calm <= !calm;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : check_results
    tok_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (tok_q.size() == 0) begin
        report_mismatch("unexpected token kind", kind, -1);
      end else begin
        want = tok_q.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (content_byte !== want.data)
          report_mismatch("content_byte", content_byte, want.data);
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", last_of_run, want.last);
      end
    end
  end

  // Hold the receiver off long enough to back the block up into its input
  initial begin : hold_receiver
    wait (acc_count >= 150 && text_q.size() > 20);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    logic [7:0] delims[7];
    delims = '{8'h00, 8'hFF, ChQuote, 8'h3B, 8'h09, 8'h00, DelimReset};
    delims[5] = 8'($urandom_range(0, 255));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed text under the reset delimiter
    push_item("a", 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(",", 1'b0);
    push_item(ChNul, 1'b0);      // zero byte after delimiter
    push_item(",", 1'b0);
    push_item(ChQuote, 1'b0);
    push_item(",", 1'b0);        // delimiter as quoted content
    push_item(ChQuote, 1'b0);
    push_item(ChQuote, 1'b0);    // doubled quote
    push_item(ChQuote, 1'b0);
    push_item("z", 1'b0);        // other byte after closing quote
    push_item(",", 1'b0);
    push_item(ChCr, 1'b0);       // line end after delimiter
    push_item("q", 1'b0);        // non-LF after CR
    push_item(ChCr, 1'b0);
    push_item(ChLf, 1'b1);       // LF after CR that ends the text
    push_item(ChQuote, 1'b0);
    push_item(ChNul, 1'b1);      // unterminated quoted field
    push_item("b", 1'b0);
    push_item(",", 1'b1);        // trailing delimiter
    push_item(ChLf, 1'b0);       // lone LF at row start
    push_item(ChQuote, 1'b0);
    push_item(ChQuote, 1'b0);
    push_item(ChLf, 1'b1);
    push_item(",", 1'b0);
    push_item(ChNul, 1'b1);      // three tokens from one byte
    gen_phase(32);
    wait_drained();

    // Walk through the delimiter settings, draining between them
    foreach (delims[i]) begin
      write_delim(delims[i]);
      gen_phase(32);
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== csv_field_row_tokenizer_core.f =====
rtl/cft_pkg.sv
rtl/cft_parser.sv
rtl/cft_emitter.sv
rtl/csv_field_row_tokenizer_core.sv
tb/tb.sv
